/* design/srr_pkg.sv */
`default_nettype none

package srr_pkg;

	localparam int SEQ_W = 31;
	localparam int LEN_W = 16;
	localparam int CK_W = 16;
	localparam int SUM_W = 32;
	localparam int WIN_W = 7;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	// Register map: the register index is paddr[2].
	localparam logic REG_TOTAL = 1'b0;
	localparam logic REG_WINDOW = 1'b1;

	localparam logic [SEQ_W-1:0] TOTAL_RESET = '0;
	localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd8;

	// Length field of an acknowledgement, part of its checksum.
	localparam logic [SUM_W-1:0] ACK_LEN = 32'd4;

	// Packet queue between the front and the back. A power of two.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [SUM_W-1:0] total;
		logic [CK_W-1:0]  ck;
	} pkt_t;

	typedef struct packed {
		logic [SEQ_W-1:0] total_packets;
		logic [WIN_W-1:0] window_size;
	} cfg_t;

	typedef struct packed {
		logic             clearing;
		logic [SEQ_W-1:0] base;
	} status_t;

	typedef struct packed {
		logic             send_ack;
		logic [SEQ_W-1:0] ack_number;
		logic [CK_W-1:0]  ack_checksum;
		logic             corrupt_flag;
		logic             duplicate_flag;
		logic [SEQ_W-1:0] next_expected;
		logic             transfer_done;
	} result_t;

	// Folds the carries of a 32-bit sum into 16 bits and complements it.
	// Two folds always suffice: the first leaves at most 0x1FFFE.
	function automatic logic [CK_W-1:0] fold_complement(input logic [SUM_W-1:0] s);
		logic [16:0] s1;
		logic [15:0] s2;
		s1 = {1'b0, s[15:0]} + {1'b0, s[31:16]};
		s2 = s1[15:0] + {15'b0, s1[16]};
		return ~s2;
	endfunction

endpackage

`default_nettype wire

/* design/srr_ram.sv */
`default_nettype none

module srr_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* design/srr_front.sv */
`default_nettype none

module srr_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         hold,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [srr_pkg::SEQ_W-1:0]    seq_number,
	input  wire logic [srr_pkg::LEN_W-1:0]    payload_length,
	input  wire logic [srr_pkg::CK_W-1:0]     packet_checksum,
	input  wire logic [7:0]                   data_byte,
	input  wire logic                         byte_valid,
	input  wire logic                         last_item,
	output logic                              push,
	output srr_pkg::pkt_t                     push_pkt
);

	logic [srr_pkg::SUM_W-1:0] sum_q;
	logic [srr_pkg::SUM_W-1:0] sum_plus;
	logic                      accept;

	assign in_stall = hold;
	assign accept = in_valid && !hold;
	assign sum_plus = sum_q + (byte_valid ? {24'b0, data_byte} : '0);

	// The whole check sum is formed here, so the back only folds it.
	assign push = accept && last_item;
	assign push_pkt.seq = seq_number;
	assign push_pkt.total = sum_plus + {16'b0, payload_length} + {1'b0, seq_number};
	assign push_pkt.ck = packet_checksum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (accept) begin
			sum_q <= last_item ? '0 : sum_plus;
		end
	end

endmodule

`default_nettype wire

/* design/srr_queue.sv */
`default_nettype none

module srr_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire srr_pkg::pkt_t push_pkt,
	output logic               full,
	input  wire logic          pop,
	output logic               not_empty,
	output srr_pkg::pkt_t      head_pkt
);

	srr_pkg::pkt_t              entries_q [srr_pkg::QUEUE_DEPTH];
	logic [srr_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [srr_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [srr_pkg::QPTR_W:0]   count_q;

	assign full = count_q == (srr_pkg::QPTR_W+1)'(srr_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head_pkt = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/srr_back.sv */
`default_nettype none

module srr_back #(
	parameter int RING_SIZE = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire srr_pkg::cfg_t cfg,
	input  wire logic          q_not_empty,
	input  wire srr_pkg::pkt_t q_head,
	output logic               q_pop,
	output srr_pkg::status_t   status,
	output logic               out_valid,
	input  wire logic          out_stall,
	output srr_pkg::result_t   result
);

	localparam int IW = $clog2(RING_SIZE);
	localparam int CW = $clog2(RING_SIZE + 1);

	localparam logic [3:0] ST_CLEAR   = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_CHECK   = 4'd2;
	localparam logic [3:0] ST_ADV_RD  = 4'd3;
	localparam logic [3:0] ST_ADV_WT  = 4'd4;
	localparam logic [3:0] ST_LOOK    = 4'd5;
	localparam logic [3:0] ST_LOOK_WT = 4'd6;
	localparam logic [3:0] ST_DECIDE  = 4'd7;
	localparam logic [3:0] ST_EMIT    = 4'd8;

	logic [3:0]                state_q;
	srr_pkg::pkt_t             pkt_q;
	logic                      corrupt_q;
	logic                      dup_q;
	logic                      ack_q;
	logic                      final_q;
	logic [CW-1:0]             step_q;
	logic [srr_pkg::SEQ_W-1:0] base_q;
	logic [IW-1:0]             base_slot_q;
	logic [IW-1:0]             seq_slot_q;
	logic [IW-1:0]             clr_addr_q;
	srr_pkg::result_t          res_q;
	logic                      out_valid_q;

	logic                      ram_we;
	logic [IW-1:0]             ram_waddr;
	logic                      ram_wdata;
	logic [IW-1:0]             ram_raddr;
	logic                      ram_rdata;

	logic                      below;
	logic [srr_pkg::SEQ_W-1:0] diff;
	logic                      near;
	logic [31:0]               win;
	logic                      in_win;
	logic                      adv_stop;
	logic [IW:0]               slot_sum;
	logic [IW-1:0]             seq_slot;
	logic [IW-1:0]             base_slot_next;
	logic                      take;
	logic                      out_free;
	logic                      done_now;

	srr_ram #(
		.WIDTH(1),
		.DEPTH(RING_SIZE)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Window tests against the current base.
	assign below = pkt_q.seq < base_q;
	assign diff = pkt_q.seq - base_q;
	assign near = {1'b0, diff} < 32'(RING_SIZE);
	assign win = ({25'b0, cfg.window_size} > 32'(RING_SIZE)) ? 32'(RING_SIZE)
		: {25'b0, cfg.window_size};
	assign in_win = !below && (pkt_q.seq < cfg.total_packets) && ({1'b0, diff} < win);

	assign done_now = base_q >= cfg.total_packets;
	assign adv_stop = done_now || (step_q == CW'(RING_SIZE));

	// Ring slot of the sequence number, valid whenever it is within a ring of the base.
	assign slot_sum = {1'b0, base_slot_q} + diff[IW:0];
	assign seq_slot = (slot_sum >= (IW+1)'(RING_SIZE)) ?
		IW'(slot_sum - (IW+1)'(RING_SIZE)) : slot_sum[IW-1:0];
	assign base_slot_next = (base_slot_q == IW'(RING_SIZE - 1)) ? '0 : base_slot_q + 1'b1;

	assign take = !corrupt_q && !dup_q && in_win;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = base_slot_q;
		ram_wdata = 1'b0;
		ram_raddr = base_slot_q;
		q_pop = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_addr_q;
			end
			ST_IDLE: begin
				q_pop = q_not_empty;
			end
			ST_ADV_WT: begin
				ram_we = ram_rdata;
			end
			ST_LOOK: begin
				ram_raddr = seq_slot;
			end
			ST_DECIDE: begin
				ram_we = take;
				ram_waddr = seq_slot_q;
				ram_wdata = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_not_empty) begin
			pkt_q <= q_head;
		end
		if (state_q == ST_CHECK) begin
			corrupt_q <= srr_pkg::fold_complement(pkt_q.total) != pkt_q.ck;
		end
		if (state_q == ST_LOOK) begin
			seq_slot_q <= seq_slot;
			dup_q <= below;
		end
		if (state_q == ST_LOOK_WT) begin
			dup_q <= ram_rdata;
		end
		if (state_q == ST_DECIDE) begin
			ack_q <= !corrupt_q && (dup_q || in_win);
		end
		if (state_q == ST_EMIT && out_free) begin
			res_q.send_ack <= ack_q;
			res_q.ack_number <= ack_q ? pkt_q.seq : '0;
			res_q.ack_checksum <= ack_q ?
				srr_pkg::fold_complement(srr_pkg::ACK_LEN + {1'b0, pkt_q.seq}) : '0;
			res_q.corrupt_flag <= corrupt_q;
			res_q.duplicate_flag <= dup_q;
			res_q.next_expected <= base_q;
			res_q.transfer_done <= done_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_addr_q <= '0;
			base_q <= '0;
			base_slot_q <= '0;
			step_q <= '0;
			final_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == IW'(RING_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_not_empty) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (in_win) begin
						state_q <= ST_LOOK;
					end else begin
						final_q <= 1'b0;
						step_q <= '0;
						state_q <= ST_ADV_RD;
					end
				end
				ST_ADV_RD: begin
					if (adv_stop) begin
						state_q <= final_q ? ST_EMIT : ST_LOOK;
					end else begin
						state_q <= ST_ADV_WT;
					end
				end
				ST_ADV_WT: begin
					if (ram_rdata) begin
						base_q <= base_q + 1'b1;
						base_slot_q <= base_slot_next;
						step_q <= step_q + CW'(1);
						state_q <= ST_ADV_RD;
					end else begin
						state_q <= final_q ? ST_EMIT : ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (!below && near) begin
						state_q <= ST_LOOK_WT;
					end else begin
						state_q <= ST_DECIDE;
					end
				end
				ST_LOOK_WT: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (take) begin
						final_q <= 1'b1;
						step_q <= '0;
						state_q <= ST_ADV_RD;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign status.clearing = state_q == ST_CLEAR;
	assign status.base = base_q;
	assign out_valid = out_valid_q;
	assign result = res_q;

endmodule

`default_nettype wire

/* design/selective_repeat_receiver.sv */
// Payload words are taken at one per cycle while in_stall is low; a packet's last word
// enters a four-deep queue. Each pass that steps the window base covers at most RING_SIZE
// ring slots, with two passes at most per packet. The back end works on one packet at a
// time, as the single ring RAM port serves both the lookup and the stepping. After arst_n
// the ring RAM is cleared with in_stall high. Reset sets total_packets to 0, window_size
// to 8, and the window base and the byte sum to 0.
`default_nettype none

module selective_repeat_receiver #(
	parameter int RING_SIZE = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [srr_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [srr_pkg::DATA_W-1:0]    pwdata,
	output logic      [srr_pkg::DATA_W-1:0]    prdata,
	output logic                               pready,

	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [srr_pkg::SEQ_W-1:0]     seq_number,
	input  wire logic [srr_pkg::LEN_W-1:0]     payload_length,
	input  wire logic [srr_pkg::CK_W-1:0]      packet_checksum,
	input  wire logic [7:0]                    data_byte,
	input  wire logic                          byte_valid,
	input  wire logic                          last_item,

	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               send_ack,
	output logic      [srr_pkg::SEQ_W-1:0]     ack_number,
	output logic      [srr_pkg::CK_W-1:0]      ack_checksum,
	output logic                               corrupt_flag,
	output logic                               duplicate_flag,
	output logic      [srr_pkg::SEQ_W-1:0]     next_expected,
	output logic                               transfer_done
);

	// Configuration registers. Only paddr[2] selects a register; the low address bits
	// are ignored, so every write lands in one of the two.
	logic [srr_pkg::SEQ_W-1:0] total_q;
	logic [srr_pkg::WIN_W-1:0] window_q;
	logic                      cfg_write;
	srr_pkg::cfg_t             cfg;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg.total_packets = total_q;
	assign cfg.window_size = window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= srr_pkg::TOTAL_RESET;
			window_q <= srr_pkg::WINDOW_RESET;
		end else if (cfg_write) begin
			unique case (paddr[2])
				srr_pkg::REG_TOTAL:  total_q <= pwdata[srr_pkg::SEQ_W-1:0];
				srr_pkg::REG_WINDOW: window_q <= pwdata[srr_pkg::WIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			srr_pkg::REG_TOTAL:  prdata = {1'b0, total_q};
			srr_pkg::REG_WINDOW: prdata = {25'b0, window_q};
			default:             prdata = '0;
		endcase
	end

	// The front end sums the payload words of a packet and, on its last word, hands the
	// header and the full check sum to the queue. It holds off input while the ring is
	// being cleared or while the queue has no room.
	logic              q_full;
	logic              q_push;
	srr_pkg::pkt_t     q_push_pkt;
	logic              q_pop;
	logic              q_not_empty;
	srr_pkg::pkt_t     q_head;
	srr_pkg::status_t  status;
	srr_pkg::result_t  result;

	srr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.hold           (status.clearing || q_full),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.seq_number     (seq_number),
		.payload_length (payload_length),
		.packet_checksum(packet_checksum),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.last_item      (last_item),
		.push           (q_push),
		.push_pkt       (q_push_pkt)
	);

	// The queue lets the next packet's bytes stream in while the back end is still
	// stepping the window for the previous one.
	srr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_pkt (q_push_pkt),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.head_pkt (q_head)
	);

	// The back end checks the packet, looks up and marks the received ring, advances the
	// window base one slot at a time, and loads the output register. The output
	// register frees the back end to start on the next packet while a result waits.
	srr_back #(
		.RING_SIZE(RING_SIZE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_not_empty(q_not_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.status     (status),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (result)
	);

	assign send_ack = result.send_ack;
	assign ack_number = result.ack_number;
	assign ack_checksum = result.ack_checksum;
	assign corrupt_flag = result.corrupt_flag;
	assign duplicate_flag = result.duplicate_flag;
	assign next_expected = result.next_expected;
	assign transfer_done = result.transfer_done;

	// A corrupt packet is never acknowledged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_ack |-> !corrupt_flag)
		else $error("acknowledgement sent for a corrupt packet");

	// An intact duplicate is always acknowledged again.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && duplicate_flag && !corrupt_flag |-> send_ack)
		else $error("intact duplicate not acknowledged");

	// Without an acknowledgement the number and checksum read zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !send_ack |-> ack_number == '0 && ack_checksum == '0)
		else $error("acknowledgement fields set without an acknowledgement");

	// The window base never moves backward.
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> status.base >= $past(status.base))
		else $error("window base moved backward");

endmodule

`default_nettype wire

/* verif/tb_selective_repeat_receiver.sv */
`timescale 1ns / 1ps

// Testbench for the selective-repeat receiver.
// Words are pushed into the block through a valid/stall channel, one payload byte per word.
// A running predictor follows every accepted word, and on each packet-closing word it decides
// the acknowledgement, the flags and the new window base. Those decisions queue up in order
// and are compared field by field against the result words that come out of the block.
module tb_selective_repeat_receiver;

	localparam int SEQ_W = srr_pkg::SEQ_W;
	localparam int LEN_W = srr_pkg::LEN_W;
	localparam int CK_W = srr_pkg::CK_W;
	localparam int SUM_W = srr_pkg::SUM_W;
	localparam int WIN_W = srr_pkg::WIN_W;
	localparam int DATA_W = srr_pkg::DATA_W;
	localparam int ADDR_W = srr_pkg::ADDR_W;

	localparam int RING = 64;
	localparam int RING_W = $clog2(RING);
	// Cycles that may pass after the last result before the block is surely quiet: the back end
	// can step over the whole ring twice for one packet.
	localparam int QUIET_CYCLES = 300;
	localparam int WORD_TARGET = 1050;
	localparam int PHASE_WORDS = 180;
	localparam logic [SEQ_W-1:0] SEQ_MAX = '1;
	localparam logic [ADDR_W-1:0] ADDR_TOTAL = {srr_pkg::REG_TOTAL, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_WINDOW = {srr_pkg::REG_WINDOW, 2'b00};

	// One input word as it is driven onto the ports.
	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [LEN_W-1:0] len;
		logic [CK_W-1:0]  ck;
		logic [7:0]       data;
		logic             byte_valid;
		logic             last_item;
	} word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	logic in_valid = 1'b0;
	logic in_stall;
	logic [SEQ_W-1:0] seq_number = '0;
	logic [LEN_W-1:0] payload_length = '0;
	logic [CK_W-1:0] packet_checksum = '0;
	logic [7:0] data_byte = '0;
	logic byte_valid = 1'b0;
	logic last_item = 1'b0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic send_ack;
	logic [SEQ_W-1:0] ack_number;
	logic [CK_W-1:0] ack_checksum;
	logic corrupt_flag;
	logic duplicate_flag;
	logic [SEQ_W-1:0] next_expected;
	logic transfer_done;

	// Predictor state: which ring slots hold a received packet, the window base, the byte sum
	// of the packet in progress, and the two configuration registers.
	logic [RING-1:0] rx_map = '0;
	logic [SEQ_W-1:0] base_seq = '0;
	logic [SUM_W-1:0] byte_sum = '0;
	logic [SEQ_W-1:0] cfg_total = srr_pkg::TOTAL_RESET;
	logic [WIN_W-1:0] cfg_window = srr_pkg::WINDOW_RESET;

	// Acknowledgement decisions still waiting for their result word, oldest first.
	srr_pkg::result_t ack_decisions[$];

	int fail_count = 0;
	int words_sent = 0;
	int src_gap_max = 11;
	int sink_gap_max = 11;
	int sink_wait = 0;
	int sink_hold_cycles = 0;

	selective_repeat_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.seq_number(seq_number),
		.payload_length(payload_length),
		.packet_checksum(packet_checksum),
		.data_byte(data_byte),
		.byte_valid(byte_valid),
		.last_item(last_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.send_ack(send_ack),
		.ack_number(ack_number),
		.ack_checksum(ack_checksum),
		.corrupt_flag(corrupt_flag),
		.duplicate_flag(duplicate_flag),
		.next_expected(next_expected),
		.transfer_done(transfer_done)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Ones-complement checksum: fold the carries back in until the sum fits in 16 bits,
	// then invert.
	function automatic logic [CK_W-1:0] ones_fold(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] v;
		v = s;
		while (v[31:16] != 16'd0)
			v = {16'd0, v[15:0]} + {16'd0, v[31:16]};
		return ~v[15:0];
	endfunction

	// A sequence number counts as already received when it lies below the base, or when its
	// ring slot is marked and it is less than one ring ahead of the base.
	function automatic bit seq_seen(input logic [SEQ_W-1:0] s);
		if (s < base_seq)
			return 1'b1;
		if (({1'b0, s} - {1'b0, base_seq}) < 32'(RING))
			return rx_map[s[RING_W-1:0]];
		return 1'b0;
	endfunction

	// The window never exceeds the ring, and nothing at or past the total is admitted.
	function automatic bit seq_in_window(input logic [SEQ_W-1:0] s);
		logic [SUM_W-1:0] width;
		width = ({25'b0, cfg_window} > 32'(RING)) ? 32'(RING) : {25'b0, cfg_window};
		if (s < base_seq || s >= cfg_total)
			return 1'b0;
		return ({1'b0, s} - {1'b0, base_seq}) < width;
	endfunction

	// Walk the base forward over received slots, clearing each, for at most one ring's worth.
	function automatic void slide_base();
		for (int n = 0; n < RING; n++) begin
			if (base_seq >= cfg_total || !rx_map[base_seq[RING_W-1:0]])
				break;
			rx_map[base_seq[RING_W-1:0]] = 1'b0;
			base_seq = base_seq + 1'b1;
		end
	endfunction

	// Apply one accepted word to the predictor. A packet-closing word yields exactly one
	// decision. The base is re-advanced first when the packet is outside the window, which
	// matters once the total has been raised over slots that were already received.
	function automatic void judge_word(input word_t w);
		srr_pkg::result_t r;
		logic [SUM_W-1:0] total;
		bit bad;
		bit dup;
		bit ack;
		if (w.byte_valid)
			byte_sum = byte_sum + {24'b0, w.data};
		if (!w.last_item)
			return;
		total = byte_sum + {16'b0, w.len} + {1'b0, w.seq};
		byte_sum = '0;
		bad = ones_fold(total) != w.ck;
		if (!seq_in_window(w.seq))
			slide_base();
		dup = seq_seen(w.seq);
		ack = 1'b0;
		if (!bad) begin
			if (dup) begin
				ack = 1'b1;
			end else if (seq_in_window(w.seq)) begin
				rx_map[w.seq[RING_W-1:0]] = 1'b1;
				ack = 1'b1;
				slide_base();
			end
		end
		r.send_ack = ack;
		r.ack_number = ack ? w.seq : '0;
		r.ack_checksum = ack ? ones_fold(srr_pkg::ACK_LEN + {1'b0, w.seq}) : '0;
		r.corrupt_flag = bad;
		r.duplicate_flag = dup;
		r.next_expected = base_seq;
		r.transfer_done = base_seq >= cfg_total;
		ack_decisions.push_back(r);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Result side. The stall is driven at the falling edge: a long hold asked for by a test
	// takes priority, otherwise the block waits out the gap drawn at the last accepted word.
	always @(negedge clk) begin
		if (sink_hold_cycles > 0) begin
			out_stall <= 1'b1;
			sink_hold_cycles--;
		end else if (sink_wait > 0) begin
			out_stall <= 1'b1;
			sink_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Every accepted result word is matched against the oldest pending decision.
	always @(posedge clk) begin
		srr_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			sink_wait = $urandom_range(0, sink_gap_max);
			if (ack_decisions.size() == 0) begin
				$error("result word arrived with no packet outstanding");
				fail_count++;
			end else begin
				want = ack_decisions.pop_front();
				check_field("send_ack", 32'(want.send_ack), 32'(send_ack));
				check_field("ack_number", 32'(want.ack_number), 32'(ack_number));
				check_field("ack_checksum", 32'(want.ack_checksum), 32'(ack_checksum));
				check_field("corrupt_flag", 32'(want.corrupt_flag), 32'(corrupt_flag));
				check_field("duplicate_flag", 32'(want.duplicate_flag),
					32'(duplicate_flag));
				check_field("next_expected", 32'(want.next_expected), 32'(next_expected));
				check_field("transfer_done", 32'(want.transfer_done), 32'(transfer_done));
			end
		end
	end

	// Register write followed by a readback. Called and left at a falling edge. The register
	// takes the write at the rising edge of the access cycle, and the read data is sampled at
	// the rising edge of its own access cycle.
	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		logic [DATA_W-1:0] stored;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (addr[2] == srr_pkg::REG_TOTAL) begin
			cfg_total = data[SEQ_W-1:0];
			stored = {{(DATA_W-SEQ_W){1'b0}}, data[SEQ_W-1:0]};
		end else begin
			cfg_window = data[WIN_W-1:0];
			stored = {{(DATA_W-WIN_W){1'b0}}, data[WIN_W-1:0]};
		end
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("prdata", stored, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Offer one word after a random gap and hold it until the block takes it. The valid stays
	// high into the next word when no gap is drawn.
	task automatic send_word(input word_t w);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		seq_number <= w.seq;
		payload_length <= w.len;
		packet_checksum <= w.ck;
		data_byte <= w.data;
		byte_valid <= w.byte_valid;
		last_item <= w.last_item;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		judge_word(w);
		words_sent++;
		@(negedge clk);
	endtask

	// One packet of nbytes words; zero gives an empty packet of a single word with no valid
	// byte. Header fields on the inner words are random, since only the closing word's header
	// counts. The checksum is built over whatever the byte sum already holds, so stray words
	// in front of the packet are covered. A fill of -1 means random bytes.
	task automatic send_packet(input logic [SEQ_W-1:0] seq, input int nbytes,
			input logic [LEN_W-1:0] len, input bit bad, input int fill);
		word_t w;
		int count;
		count = (nbytes < 1) ? 1 : nbytes;
		for (int i = 0; i < count; i++) begin
			w.seq = SEQ_W'($urandom);
			w.len = LEN_W'($urandom);
			w.ck = CK_W'($urandom);
			w.data = (fill < 0) ? 8'($urandom) : 8'(fill);
			w.byte_valid = (nbytes > 0) && (fill >= 0 || $urandom_range(0, 7) != 0);
			w.last_item = (i == count - 1);
			if (w.last_item) begin
				w.seq = seq;
				w.len = len;
				w.ck = ones_fold(byte_sum + {24'b0, (w.byte_valid ? w.data : 8'd0)}
					+ {16'b0, len} + {1'b0, seq});
				if (bad)
					w.ck = w.ck ^ CK_W'($urandom_range(1, 16'hFFFF));
			end
			send_word(w);
		end
	endtask

	// Drop the valid, wait for every decision to be matched, then let the back end settle,
	// since a stray word or a long base walk may still be in flight.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (ack_decisions.size() != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	// Out of reset the total is zero, so nothing is admitted and the transfer reads as done.
	task automatic test_reset_defaults();
		send_packet('0, 1, 16'h0000, 1'b0, 8'h00);
		send_packet(31'd5, 1, 16'h1234, 1'b0, -1);
		wait_idle();
	endtask

	// Walk the window by hand: in-order and out-of-order arrivals, duplicates below the base
	// and inside the ring, an empty packet, a corrupt packet, a packet just past the window,
	// one a full ring ahead, and the largest sequence number with the widest fields.
	task automatic test_window_walk();
		write_reg(ADDR_TOTAL, 32'd20);
		write_reg(ADDR_WINDOW, 32'd8);
		send_packet(31'd0, 1, 16'hFFFF, 1'b0, 8'hFF);
		send_packet(31'd0, 1, 16'h0001, 1'b0, 8'h00);
		send_packet(31'd2, 2, 16'h00A5, 1'b0, -1);
		send_packet(31'd1, 0, 16'h0000, 1'b0, -1);
		send_packet(31'd2, 1, 16'h5A00, 1'b0, -1);
		send_packet(31'd3, 2, 16'h0010, 1'b1, -1);
		send_packet(31'd11, 1, 16'h0020, 1'b0, -1);
		send_packet(31'd10, 1, 16'h0030, 1'b0, -1);
		send_packet(31'd10, 1, 16'h0030, 1'b0, -1);
		send_packet(31'd67, 1, 16'h0040, 1'b0, -1);
		send_packet(SEQ_MAX, 1, 16'hFFFF, 1'b0, 8'hFF);
		wait_idle();
	endtask

	// Register extremes: a total shrunk below the base, a zero window, a window wider than
	// the ring (it acts as the ring), a one-packet window, and the largest total.
	task automatic test_window_limits();
		write_reg(ADDR_TOTAL, 32'd2);
		send_packet(31'd3, 1, 16'h0001, 1'b0, -1);
		wait_idle();
		write_reg(ADDR_TOTAL, {1'b1, SEQ_MAX});
		write_reg(ADDR_WINDOW, 32'd0);
		send_packet(31'd3, 1, 16'h0002, 1'b0, -1);
		wait_idle();
		write_reg(ADDR_WINDOW, 32'hFFFF_FF7F);
		send_packet(31'd66, 1, 16'h0003, 1'b0, -1);
		send_packet(31'd67, 1, 16'h0004, 1'b0, -1);
		wait_idle();
		write_reg(ADDR_WINDOW, 32'd1);
		send_packet(31'd4, 1, 16'h0005, 1'b0, -1);
		send_packet(31'd3, 1, 16'h0006, 1'b0, -1);
		wait_idle();
	endtask

	// The result side holds off for a long stretch while short in-order packets keep coming
	// back to back, so the packet queue fills and the input stalls. Afterwards the sender
	// pauses until every decision has been matched.
	task automatic test_backpressure();
		logic [SEQ_W-1:0] start;
		write_reg(ADDR_TOTAL, 32'd100000);
		write_reg(ADDR_WINDOW, 32'd64);
		start = base_seq;
		src_gap_max = 0;
		@(posedge clk);
		sink_hold_cycles = 400;
		@(negedge clk);
		for (int i = 0; i < 40; i++)
			send_packet(start + SEQ_W'(i), $urandom_range(1, 2), LEN_W'($urandom), 1'b0, -1);
		wait_idle();
		src_gap_max = 11;
	endtask

	// Random traffic in phases, each with its own register setting and idling profile. Most
	// packets land on or near the base so the window really moves; the rest are duplicates
	// below the base, packets a ring ahead, wild sequence numbers and stray unterminated words.
	task automatic test_random_traffic();
		int phase;
		int phase_end;
		int pick;
		int reach;
		int back;
		logic [SEQ_W-1:0] seq;
		phase = 0;
		while (words_sent < WORD_TARGET) begin
			wait_idle();
			src_gap_max = 11;
			sink_gap_max = 11;
			case (phase % 6)
				0: begin
					write_reg(ADDR_TOTAL, {1'b0, base_seq} + 32'd150);
					write_reg(ADDR_WINDOW, 32'd8);
				end
				1: begin
					// A stretch with no idling on either side.
					src_gap_max = 0;
					sink_gap_max = 0;
					write_reg(ADDR_TOTAL, {1'b0, base_seq} + 32'd400);
					write_reg(ADDR_WINDOW, 32'd64);
				end
				2: begin
					write_reg(ADDR_TOTAL, {1'b0, SEQ_MAX});
					write_reg(ADDR_WINDOW, {25'($urandom), 7'd127});
				end
				3: begin
					src_gap_max = 0;
					write_reg(ADDR_TOTAL, {1'b0, base_seq} + 32'($urandom_range(20, 200)));
					write_reg(ADDR_WINDOW, 32'd1);
				end
				4: begin
					// A short total so the transfer completes inside the phase.
					write_reg(ADDR_TOTAL, {1'b0, base_seq} + 32'd30);
					write_reg(ADDR_WINDOW, 32'($urandom_range(1, 64)));
				end
				default: begin
					sink_gap_max = 0;
					write_reg(ADDR_TOTAL, {2'b0, base_seq[SEQ_W-1:1]});
					write_reg(ADDR_WINDOW, 32'($urandom_range(1, 127)));
				end
			endcase
			phase_end = words_sent + PHASE_WORDS;
			while (words_sent < phase_end && words_sent < WORD_TARGET) begin
				reach = (cfg_window > WIN_W'(RING)) ? RING : int'(cfg_window);
				pick = $urandom_range(0, 99);
				if (pick < 35) begin
					seq = base_seq + SEQ_W'($urandom_range(0, 2));
				end else if (pick < 70) begin
					seq = base_seq + SEQ_W'($urandom_range(0, reach + 3));
				end else if (pick < 80) begin
					back = $urandom_range(0, 10);
					if (back > int'(base_seq))
						back = int'(base_seq);
					seq = base_seq - SEQ_W'(back);
				end else if (pick < 88) begin
					seq = SEQ_W'($urandom);
				end else if (pick < 94) begin
					seq = base_seq + SEQ_W'(RING - 1) + SEQ_W'($urandom_range(0, 3));
				end else begin
					// Stray words with no closing word; their bytes fold into the next packet.
					repeat ($urandom_range(1, 3))
						send_word({SEQ_W'($urandom), LEN_W'($urandom), CK_W'($urandom),
							8'($urandom), 1'($urandom), 1'b0});
					continue;
				end
				if ($urandom_range(0, 19) == 0)
					send_packet(seq, $urandom_range(0, 20), LEN_W'($urandom),
						$urandom_range(0, 9) == 0, -1);
				else
					send_packet(seq, $urandom_range(1, 6), LEN_W'($urandom),
						$urandom_range(0, 9) == 0, -1);
			end
			phase++;
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// The ring is cleared after reset with the input stalled; stay idle until it is done.
		do @(negedge clk); while (in_stall !== 1'b0);
		test_reset_defaults();
		test_window_walk();
		test_window_limits();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Hard stop, several times the slowest correct run.
	initial begin
		#12_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
